>>> hdl/reva_pkg.sv
// Shared types, codes and the quadrature transition table for the value
// adjust block.
package reva_pkg;

  // Field widths.
  localparam int VALUE_W = 8;
  localparam int SUM_W   = VALUE_W + 1;
  localparam int STEP_W  = 7;
  localparam int PHASE_W = 3;
  localparam int EVENT_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // Command carried in the input tuser.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  // Direction event codes on the output.
  localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
  localparam logic [EVENT_W-1:0] EV_CW   = 2'd1;
  localparam logic [EVENT_W-1:0] EV_CCW  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 2'd2;

  // Decoder phases.
  localparam logic [PHASE_W-1:0] PH_START = 3'd0;
  localparam logic [PHASE_W-1:0] PH_BAD   = 3'd7;

  // One step of the decoder: next phase and the events it raises.
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               cw;
    logic               ccw;
  } dec_step_t;

  // Transition table indexed by phase and pin code {pin_b, pin_a}.
  localparam dec_step_t DEC_TABLE [7][4] = '{
    '{'{3'd0, 1'b0, 1'b0}, '{3'd4, 1'b0, 1'b0}, '{3'd1, 1'b0, 1'b0}, '{3'd0, 1'b0, 1'b0}},
    '{'{3'd2, 1'b1, 1'b0}, '{3'd0, 1'b0, 1'b0}, '{3'd1, 1'b0, 1'b0}, '{3'd0, 1'b0, 1'b0}},
    '{'{3'd2, 1'b0, 1'b0}, '{3'd3, 1'b0, 1'b0}, '{3'd1, 1'b0, 1'b0}, '{3'd0, 1'b0, 1'b0}},
    '{'{3'd2, 1'b0, 1'b0}, '{3'd3, 1'b0, 1'b0}, '{3'd0, 1'b0, 1'b0}, '{3'd0, 1'b1, 1'b0}},
    '{'{3'd5, 1'b0, 1'b1}, '{3'd4, 1'b0, 1'b0}, '{3'd0, 1'b0, 1'b0}, '{3'd0, 1'b0, 1'b0}},
    '{'{3'd5, 1'b0, 1'b0}, '{3'd4, 1'b0, 1'b0}, '{3'd6, 1'b0, 1'b0}, '{3'd0, 1'b0, 1'b0}},
    '{'{3'd5, 1'b0, 1'b0}, '{3'd0, 1'b0, 1'b0}, '{3'd6, 1'b0, 1'b0}, '{3'd0, 1'b0, 1'b1}}
  };

endpackage

>>> hdl/reva_decode.sv
// Quadrature decoder step: looks up the next phase and any event for one
// request. A load request leaves the phase alone and raises nothing.
module reva_decode
  import reva_pkg::*;
(
  input  logic               cmd,
  input  logic               pin_a,
  input  logic               pin_b,
  input  logic [PHASE_W-1:0] phase,
  output dec_step_t          step
);

  logic [PHASE_W-1:0] phase_idx;
  logic [1:0]         code;

  // An impossible phase is handled as the start phase.
  assign phase_idx = (phase == PH_BAD) ? PH_START : phase;
  assign code      = {pin_b, pin_a};

  always_comb begin
    if (cmd == CMD_LOAD) begin
      step = '{phase: phase, cw: 1'b0, ccw: 1'b0};
    end else begin
      step = DEC_TABLE[phase_idx][code];
    end
  end

endmodule

>>> hdl/reva_adjust.sv
// Value update: a load replaces the value, an event moves it by the step size
// while the value lies inside the limits, saturating at the signed 8-bit range.
module reva_adjust
  import reva_pkg::*;
(
  input  logic                      cmd,
  input  logic signed [VALUE_W-1:0] load_value,
  input  dec_step_t                 step,
  input  logic signed [VALUE_W-1:0] value,
  input  logic signed [VALUE_W-1:0] lower_limit,
  input  logic signed [VALUE_W-1:0] upper_limit,
  input  logic        [STEP_W-1:0]  step_size,
  output logic signed [VALUE_W-1:0] value_next
);

  logic signed [SUM_W-1:0] value_ext;
  logic signed [SUM_W-1:0] step_ext;
  logic signed [SUM_W-1:0] sum;
  logic signed [VALUE_W-1:0] sum_sat;

  assign value_ext = SUM_W'(value);
  assign step_ext  = signed'({{(SUM_W-STEP_W){1'b0}}, step_size});

  // Counterclockwise takes precedence; the table never raises both.
  assign sum = step.ccw ? (value_ext - step_ext) : (value_ext + step_ext);

  // Saturate when the top two bits of the sum disagree.
  always_comb begin
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      sum_sat = sum[SUM_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      sum_sat = sum[VALUE_W-1:0];
    end
  end

  always_comb begin
    priority if (cmd == CMD_LOAD) begin
      value_next = load_value;
    end else if (step.ccw && (value > lower_limit)) begin
      value_next = sum_sat;
    end else if (step.cw && (value < upper_limit)) begin
      value_next = sum_sat;
    end else begin
      value_next = value;
    end
  end

endmodule

>>> hdl/rotary_encoder_value_adjust.sv
// Rotary encoder value adjust. Each input request is either a pin sample or a
// load command and yields exactly one result carrying the value, the event and
// the decoder phase. The block takes one request every clock cycle while the
// downstream side accepts results. An accepted request is captured in the
// input register and, once the result register is empty or being emptied,
// passes through the decode and add logic into the result register. The input
// register keeps taking requests while a finished result waits for the
// downstream side, so a stall costs throughput only once both registers are
// full. Configuration writes take effect on the next clock edge and are meant
// for idle periods.
module rotary_encoder_value_adjust
  import reva_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pin_a, pin_b, load_value[7:0], zero pad
  input  logic [0:0]            s_axis_tuser,   // cmd
  // Output stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // position_value[7:0], direction_event[1:0],
                                                // decoder_state[2:0], zero pad
);

  // Configuration registers.
  logic signed [VALUE_W-1:0] lower_limit;
  logic signed [VALUE_W-1:0] upper_limit;
  logic        [STEP_W-1:0]  step_size;

  // Input register.
  logic                      in_valid;
  logic                      in_cmd;
  logic                      in_pin_a;
  logic                      in_pin_b;
  logic signed [VALUE_W-1:0] in_load_value;

  // Block state.
  logic [PHASE_W-1:0]        phase;
  logic signed [VALUE_W-1:0] value;

  // Result register.
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic [EVENT_W-1:0]        out_event;
  logic [PHASE_W-1:0]        out_phase;

  dec_step_t                 step;
  logic signed [VALUE_W-1:0] value_next;
  logic [EVENT_W-1:0]        event_next;
  logic                      advance;
  logic                      take_in;

  // A request moves on when the result register is empty or being emptied.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_limit <= {1'b1, {(VALUE_W-1){1'b0}}};
      upper_limit <= {1'b0, {(VALUE_W-1){1'b1}}};
      step_size   <= STEP_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOWER_LIMIT: lower_limit <= cfg_data[VALUE_W-1:0];
        REG_UPPER_LIMIT: upper_limit <= cfg_data[VALUE_W-1:0];
        REG_STEP_SIZE:   step_size   <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take_in) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_cmd        <= s_axis_tuser[0];
      in_pin_a      <= s_axis_tdata[0];
      in_pin_b      <= s_axis_tdata[1];
      in_load_value <= s_axis_tdata[VALUE_W+1:2];
    end
  end

  reva_decode u_decode (
    .cmd   (in_cmd),
    .pin_a (in_pin_a),
    .pin_b (in_pin_b),
    .phase (phase),
    .step  (step)
  );

  reva_adjust u_adjust (
    .cmd         (in_cmd),
    .load_value  (in_load_value),
    .step        (step),
    .value       (value),
    .lower_limit (lower_limit),
    .upper_limit (upper_limit),
    .step_size   (step_size),
    .value_next  (value_next)
  );

  assign event_next = step.ccw ? EV_CCW : (step.cw ? EV_CW : EV_NONE);

  // State update as a request passes into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      value <= '0;
    end else if (advance) begin
      phase <= step.phase;
      value <= value_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value <= value_next;
      out_event <= event_next;
      out_phase <= step.phase;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W-VALUE_W-EVENT_W-PHASE_W){1'b0}},
                          out_phase, out_event, out_value};

  // The decoder never reaches the unused phase.
  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase != PH_BAD)
    else $error("decoder reached an unused phase");

  // A load request leaves the decoder phase unchanged.
  a_load_keeps_phase: assert property (@(posedge clk) disable iff (rst)
    (advance && in_cmd == CMD_LOAD) |=> (phase == $past(phase)))
    else $error("load request changed the decoder phase");

  // A sample with no event leaves the value alone.
  a_quiet_keeps_value: assert property (@(posedge clk) disable iff (rst)
    (advance && in_cmd == CMD_SAMPLE && !step.cw && !step.ccw) |=> (value == $past(value)))
    else $error("value moved without an event");

  // The result register mirrors the block state after each request.
  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_value == value && out_phase == phase))
    else $error("result disagrees with block state");

  // A held request is never dropped while the result side is stalled.
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("stalled request lost from the input register");

endmodule
